// File: hdl/poincare_ball_inversion_3d_top_defines.svh
// ----------------------------------------------------------------------------
// poincare ball inversion 3d assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef POINCARE_BALL_INVERSION_3D_TOP_DEFINES_SVH
`define POINCARE_BALL_INVERSION_3D_TOP_DEFINES_SVH

// property holds at every edge out of reset
`define PBI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PBI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pbi_pkg.sv
// ----------------------------------------------------------------------------
// pbi_pkg
// shared types, register codes and fixed point helpers
// ----------------------------------------------------------------------------
`default_nettype none

package pbi_pkg;

   localparam int PBI_FRAC_BITS   = 16;
   localparam int PBI_QUEUE_DEPTH = 4;
   localparam int PBI_INDEX_BITS  = 8;

   localparam logic [PBI_INDEX_BITS-1:0] PBI_REG_CENTER_X = 8'd0;
   localparam logic [PBI_INDEX_BITS-1:0] PBI_REG_CENTER_Y = 8'd1;
   localparam logic [PBI_INDEX_BITS-1:0] PBI_REG_CENTER_Z = 8'd2;
   localparam logic [PBI_INDEX_BITS-1:0] PBI_REG_WEIGHT   = 8'd3;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic signed [31:0] weight;
   } pbi_cfg_type;

   typedef struct packed {
      logic signed [31:0] den;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic               zero;
   } pbi_item_type;

   function automatic logic signed [31:0] pbi_sat(input logic signed [64:0] v);
      if (v > 65'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (v < -65'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // floor of the product over 2^frac, clipped
   function automatic logic signed [31:0] pbi_fmul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input int frac);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return pbi_sat(65'(p >>> frac));
   endfunction

endpackage

`default_nettype wire

// File: hdl/pbi_front.sv
// ----------------------------------------------------------------------------
// pbi_front
// accepts points, forms denominator and numerators, flags zero denominator
// ----------------------------------------------------------------------------
`default_nettype none

module pbi_front import pbi_pkg::*; #(
   parameter int FRAC_BITS = PBI_FRAC_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pbi_cfg_type        cfg,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_in_x,
   input  wire logic signed [31:0] req_in_y,
   input  wire logic signed [31:0] req_in_z,
   input  wire logic signed [31:0] req_acc_x,
   input  wire logic signed [31:0] req_acc_y,
   input  wire logic signed [31:0] req_acc_z,
   output logic                    item_valid,
   output pbi_item_type            item,
   input  wire logic               item_full
);

   localparam logic signed [64:0] ONE = 65'sd1 <<< FRAC_BITS;

   logic en;
   logic [5:0] vld_ff, vld_in;

   // center derived terms
   logic signed [31:0] sqx_ff, sqy_ff, sqz_ff, sqx_in, sqy_in, sqz_in;
   logic signed [31:0] c2_ff, s2x_ff, s2y_ff, s2z_ff, c2_in, s2x_in, s2y_in, s2z_in;
   logic signed [31:0] c2x, c2y, c2z;

   logic signed [31:0] x1_ff, y1_ff, z1_ff, ax1_ff, ay1_ff, az1_ff;
   logic signed [31:0] xx2_ff, yy2_ff, zz2_ff, kx2_ff, ky2_ff, kz2_ff;
   logic signed [31:0] xx2_in, yy2_in, zz2_in, kx2_in, ky2_in, kz2_in;
   logic signed [31:0] x2_ff, y2_ff, z2_ff, ax2_ff, ay2_ff, az2_ff;
   logic signed [31:0] r3_ff, kx3_ff, ky3_ff, kz3_ff, px3_ff, py3_ff, pz3_ff;
   logic signed [31:0] r3_in, px3_in, py3_in, pz3_in;
   logic signed [31:0] ax3_ff, ay3_ff, az3_ff;
   logic signed [31:0] m4_ff, tx4_ff, ty4_ff, tz4_ff, m4_in, tx4_in, ty4_in, tz4_in;
   logic signed [64:0] ks4_ff, ks4_in;
   logic signed [31:0] px4_ff, py4_ff, pz4_ff, ax4_ff, ay4_ff, az4_ff;
   logic signed [31:0] den5_ff, qx5_ff, qy5_ff, qz5_ff, den5_in, qx5_in, qy5_in, qz5_in;
   logic signed [31:0] px5_ff, py5_ff, pz5_ff, ax5_ff, ay5_ff, az5_ff;
   pbi_item_type       item_ff, item_in;

   assign en         = !(vld_ff[5] && item_full);
   assign req_stall  = !en;
   assign item_valid = vld_ff[5];
   assign item       = item_ff;
   assign vld_in     = {vld_ff[4:0], req_valid};

   assign c2x = pbi_sat(65'(cfg.center_x) <<< 1);
   assign c2y = pbi_sat(65'(cfg.center_y) <<< 1);
   assign c2z = pbi_sat(65'(cfg.center_z) <<< 1);

   always_comb begin
      sqx_in = pbi_fmul(cfg.center_x, cfg.center_x, FRAC_BITS);
      sqy_in = pbi_fmul(cfg.center_y, cfg.center_y, FRAC_BITS);
      sqz_in = pbi_fmul(cfg.center_z, cfg.center_z, FRAC_BITS);
      c2_in  = pbi_sat(65'(sqx_ff) + 65'(sqy_ff) + 65'(sqz_ff));
      s2x_in = pbi_sat(65'(sqx_ff) - 65'(sqy_ff) - 65'(sqz_ff) + ONE);
      s2y_in = pbi_sat(65'(sqy_ff) - 65'(sqx_ff) - 65'(sqz_ff) + ONE);
      s2z_in = pbi_sat(65'(sqz_ff) - 65'(sqy_ff) - 65'(sqx_ff) + ONE);

      xx2_in = pbi_fmul(x1_ff, x1_ff, FRAC_BITS);
      yy2_in = pbi_fmul(y1_ff, y1_ff, FRAC_BITS);
      zz2_in = pbi_fmul(z1_ff, z1_ff, FRAC_BITS);
      kx2_in = pbi_fmul(c2x, x1_ff, FRAC_BITS);
      ky2_in = pbi_fmul(c2y, y1_ff, FRAC_BITS);
      kz2_in = pbi_fmul(c2z, z1_ff, FRAC_BITS);

      r3_in  = pbi_sat(65'(xx2_ff) + 65'(yy2_ff) + 65'(zz2_ff));
      px3_in = pbi_fmul(x2_ff, s2x_ff, FRAC_BITS);
      py3_in = pbi_fmul(y2_ff, s2y_ff, FRAC_BITS);
      pz3_in = pbi_fmul(z2_ff, s2z_ff, FRAC_BITS);

      m4_in  = pbi_fmul(c2_ff, r3_ff, FRAC_BITS);
      ks4_in = 65'(kx3_ff) + 65'(ky3_ff) + 65'(kz3_ff);
      tx4_in = pbi_sat(65'(ky3_ff) + 65'(kz3_ff) - 65'(r3_ff) - ONE);
      ty4_in = pbi_sat(65'(kx3_ff) + 65'(kz3_ff) - 65'(r3_ff) - ONE);
      tz4_in = pbi_sat(65'(ky3_ff) + 65'(kx3_ff) - 65'(r3_ff) - ONE);

      den5_in = pbi_sat(65'(m4_ff) - ks4_ff + ONE);
      qx5_in  = pbi_fmul(cfg.center_x, tx4_ff, FRAC_BITS);
      qy5_in  = pbi_fmul(cfg.center_y, ty4_ff, FRAC_BITS);
      qz5_in  = pbi_fmul(cfg.center_z, tz4_ff, FRAC_BITS);

      item_in.den  = den5_ff;
      item_in.nx   = pbi_sat(65'(px5_ff) + 65'(qx5_ff));
      item_in.ny   = pbi_sat(65'(py5_ff) + 65'(qy5_ff));
      item_in.nz   = pbi_sat(65'(pz5_ff) + 65'(qz5_ff));
      item_in.ax   = ax5_ff;
      item_in.ay   = ay5_ff;
      item_in.az   = az5_ff;
      item_in.zero = (den5_ff == 32'sd0);
   end

   always_ff @(posedge clock) begin
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      sqz_ff <= sqz_in;
      c2_ff  <= c2_in;
      s2x_ff <= s2x_in;
      s2y_ff <= s2y_in;
      s2z_ff <= s2z_in;
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         x1_ff  <= req_in_x;   y1_ff  <= req_in_y;   z1_ff  <= req_in_z;
         ax1_ff <= req_acc_x;  ay1_ff <= req_acc_y;  az1_ff <= req_acc_z;

         xx2_ff <= xx2_in;  yy2_ff <= yy2_in;  zz2_ff <= zz2_in;
         kx2_ff <= kx2_in;  ky2_ff <= ky2_in;  kz2_ff <= kz2_in;
         x2_ff  <= x1_ff;   y2_ff  <= y1_ff;   z2_ff  <= z1_ff;
         ax2_ff <= ax1_ff;  ay2_ff <= ay1_ff;  az2_ff <= az1_ff;

         r3_ff  <= r3_in;
         kx3_ff <= kx2_ff;  ky3_ff <= ky2_ff;  kz3_ff <= kz2_ff;
         px3_ff <= px3_in;  py3_ff <= py3_in;  pz3_ff <= pz3_in;
         ax3_ff <= ax2_ff;  ay3_ff <= ay2_ff;  az3_ff <= az2_ff;

         m4_ff  <= m4_in;   ks4_ff <= ks4_in;
         tx4_ff <= tx4_in;  ty4_ff <= ty4_in;  tz4_ff <= tz4_in;
         px4_ff <= px3_ff;  py4_ff <= py3_ff;  pz4_ff <= pz3_ff;
         ax4_ff <= ax3_ff;  ay4_ff <= ay3_ff;  az4_ff <= az3_ff;

         den5_ff <= den5_in;
         qx5_ff  <= qx5_in;  qy5_ff <= qy5_in;  qz5_ff <= qz5_in;
         px5_ff  <= px4_ff;  py5_ff <= py4_ff;  pz5_ff <= pz4_ff;
         ax5_ff  <= ax4_ff;  ay5_ff <= ay4_ff;  az5_ff <= az4_ff;

         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/pbi_queue.sv
// ----------------------------------------------------------------------------
// pbi_queue
// short item queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "poincare_ball_inversion_3d_top_defines.svh"

module pbi_queue import pbi_pkg::*; #(
   parameter int DEPTH = PBI_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire pbi_item_type push_item,
   output logic              full,
   input  wire logic         pop,
   output pbi_item_type      head_item,
   output logic              not_empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   pbi_item_type  data_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == FULL);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_item = data_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop  ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         data_ff[wr_ff] <= push_item;
      end
   end

   `PBI_ASSERT(a_count_range, clock, reset, count_ff <= FULL, "queue count beyond depth")
   `PBI_ASSERT_NEXT(a_count_up, clock, reset, do_push && !do_pop,
                    count_ff == $past(count_ff) + 1'b1, "queue count missed a push")
   `PBI_ASSERT_NEXT(a_count_down, clock, reset, do_pop && !do_push,
                    count_ff == $past(count_ff) - 1'b1, "queue count missed a pop")

endmodule

`default_nettype wire

// File: hdl/pbi_back.sv
// ----------------------------------------------------------------------------
// pbi_back
// pipelined divide, scale and saturating accumulate
// ----------------------------------------------------------------------------
`default_nettype none

module pbi_back import pbi_pkg::*; #(
   parameter int FRAC_BITS = PBI_FRAC_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [31:0] weight,
   input  wire logic               item_valid,
   input  wire pbi_item_type       item,
   output logic                    item_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic                    rsp_zero_denominator,
   output logic                    rsp_saturated
);

   localparam int NW = 32 + FRAC_BITS;
   localparam logic [NW-1:0] POS_LIM = {{(NW-31){1'b0}}, {31{1'b1}}};
   localparam logic [NW-1:0] NEG_LIM = {{(NW-32){1'b0}}, 1'b1, {31{1'b0}}};

   logic en;

   // divider stages, index 0 holds the magnitudes
   logic               vld_ff [NW+1];
   logic [32:0]        rem_ff [NW+1];
   logic [32:0]        rem_in [NW+1];
   logic [NW-1:0]      nq_ff  [NW+1];
   logic [NW-1:0]      nq_in  [NW+1];
   logic [31:0]        dm_ff  [NW+1];
   logic               neg_ff [NW+1];
   pbi_item_type       itm_ff [NW+1];
   logic signed [NW-1:0] num;
   logic [32:0]        sh     [NW+1];

   logic               vd_ff, vp_ff, vo_ff;
   logic signed [31:0] d_ff, d_in;
   pbi_item_type       itd_ff, itp_ff;
   logic signed [63:0] prx_ff, pry_ff, prz_ff, prx_in, pry_in, prz_in;
   logic signed [31:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic               zero_ff, sat_ff, sat_in;
   logic signed [64:0] sx, sy, sz;

   assign en       = !(vo_ff && rsp_stall);
   assign item_pop = en && item_valid;
   assign num      = {weight, {FRAC_BITS{1'b0}}};

   always_comb begin
      rem_in[0] = '0;
      nq_in[0]  = num[NW-1] ? NW'(-num) : NW'(num);
      sh[0]     = '0;
      for (int k = 1; k <= NW; k++) begin
         sh[k] = {rem_ff[k-1][31:0], nq_ff[k-1][NW-1]};
         if (sh[k] >= {1'b0, dm_ff[k-1]}) begin
            rem_in[k] = sh[k] - {1'b0, dm_ff[k-1]};
            nq_in[k]  = {nq_ff[k-1][NW-2:0], 1'b1};
         end else begin
            rem_in[k] = sh[k];
            nq_in[k]  = {nq_ff[k-1][NW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (neg_ff[NW]) begin
         d_in = (nq_ff[NW] > NEG_LIM) ? 32'sh80000000 : -$signed(nq_ff[NW][31:0]);
      end else begin
         d_in = (nq_ff[NW] > POS_LIM) ? 32'sh7fffffff : $signed(nq_ff[NW][31:0]);
      end
      prx_in = (64'(d_ff) * 64'(itd_ff.nx)) >>> FRAC_BITS;
      pry_in = (64'(d_ff) * 64'(itd_ff.ny)) >>> FRAC_BITS;
      prz_in = (64'(d_ff) * 64'(itd_ff.nz)) >>> FRAC_BITS;
      sx = 65'(itp_ff.ax) + 65'(prx_ff);
      sy = 65'(itp_ff.ay) + 65'(pry_ff);
      sz = 65'(itp_ff.az) + 65'(prz_ff);
      if (itp_ff.zero) begin
         ox_in  = itp_ff.ax;
         oy_in  = itp_ff.ay;
         oz_in  = itp_ff.az;
         sat_in = 1'b0;
      end else begin
         ox_in  = pbi_sat(sx);
         oy_in  = pbi_sat(sy);
         oz_in  = pbi_sat(sz);
         sat_in = (65'(ox_in) != sx) || (65'(oy_in) != sy) || (65'(oz_in) != sz);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NW; k++) begin
            vld_ff[k] <= 1'b0;
         end
         vd_ff <= 1'b0;
         vp_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= item_valid;
         for (int k = 1; k <= NW; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         vd_ff <= vld_ff[NW];
         vp_ff <= vd_ff;
         vo_ff <= vp_ff;
      end
      if (en) begin
         rem_ff[0] <= rem_in[0];
         nq_ff[0]  <= nq_in[0];
         dm_ff[0]  <= item.den[31] ? 32'(-item.den) : 32'(item.den);
         neg_ff[0] <= weight[31] ^ item.den[31];
         itm_ff[0] <= item;
         for (int k = 1; k <= NW; k++) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
            dm_ff[k]  <= dm_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            itm_ff[k] <= itm_ff[k-1];
         end
         d_ff    <= d_in;
         itd_ff  <= itm_ff[NW];
         prx_ff  <= prx_in;
         pry_ff  <= pry_in;
         prz_ff  <= prz_in;
         itp_ff  <= itd_ff;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         oz_ff   <= oz_in;
         zero_ff <= itp_ff.zero;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid            = vo_ff;
   assign rsp_out_x            = ox_ff;
   assign rsp_out_y            = oy_ff;
   assign rsp_out_z            = oz_ff;
   assign rsp_zero_denominator = zero_ff;
   assign rsp_saturated        = sat_ff;

endmodule

`default_nettype wire

// File: hdl/poincare_ball_inversion_3d_top.sv
// ----------------------------------------------------------------------------
// poincare_ball_inversion_3d_top
// inversion of a 3d point about a center, scaled and added to an accumulator
//
// req channel: one point and accumulator per item, taken when req_valid is
// high and req_stall low. rsp channel: new accumulator and flags, taken when
// rsp_valid is high and rsp_stall low. csr channel: register writes, always
// ready, register chosen by csr_index.
// throughput: one item per cycle while rsp_stall is low. an accepted item
// reaches rsp_valid through the six-stage front, the queue and the
// one-bit-per-stage restoring divider of 32 + FRAC_BITS stages followed
// by scale and accumulate stages.
// a stalled receiver freezes the back pipeline; the front keeps accepting
// until the queue fills, then raises req_stall.
// reset empties both pipelines and the queue and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module poincare_ball_inversion_3d_top import pbi_pkg::*; #(
   parameter int FRAC_BITS   = PBI_FRAC_BITS,
   parameter int QUEUE_DEPTH = PBI_QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [PBI_INDEX_BITS-1:0] csr_index,
   input  wire logic [31:0]               csr_data,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [31:0]        req_in_x,
   input  wire logic signed [31:0]        req_in_y,
   input  wire logic signed [31:0]        req_in_z,
   input  wire logic signed [31:0]        req_acc_x,
   input  wire logic signed [31:0]        req_acc_y,
   input  wire logic signed [31:0]        req_acc_z,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [31:0]             rsp_out_x,
   output logic signed [31:0]             rsp_out_y,
   output logic signed [31:0]             rsp_out_z,
   output logic                           rsp_zero_denominator,
   output logic                           rsp_saturated
);

   pbi_cfg_type  cfg_ff, cfg_in;
   logic         push, full, pop, not_empty;
   pbi_item_type push_item, head_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            PBI_REG_CENTER_X: cfg_in.center_x = csr_data;
            PBI_REG_CENTER_Y: cfg_in.center_y = csr_data;
            PBI_REG_CENTER_Z: cfg_in.center_z = csr_data;
            PBI_REG_WEIGHT:   cfg_in.weight   = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x <= '0;
         cfg_ff.center_y <= '0;
         cfg_ff.center_z <= '0;
         cfg_ff.weight   <= 32'sd1 <<< FRAC_BITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pbi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_in_x   (req_in_x),
      .req_in_y   (req_in_y),
      .req_in_z   (req_in_z),
      .req_acc_x  (req_acc_x),
      .req_acc_y  (req_acc_y),
      .req_acc_z  (req_acc_z),
      .item_valid (push),
      .item       (push_item),
      .item_full  (full)
   );

   pbi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .head_item (head_item),
      .not_empty (not_empty)
   );

   pbi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock                (clock),
      .reset                (reset),
      .weight               (cfg_ff.weight),
      .item_valid           (not_empty),
      .item                 (head_item),
      .item_pop             (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_x            (rsp_out_x),
      .rsp_out_y            (rsp_out_y),
      .rsp_out_z            (rsp_out_z),
      .rsp_zero_denominator (rsp_zero_denominator),
      .rsp_saturated        (rsp_saturated)
   );

endmodule

`default_nettype wire

// File: test/poincare_ball_inversion_3d_top_tb.sv
// ----------------------------------------------------------------------------
// poincare_ball_inversion_3d_top_tb
// self-checking bench for the 3d ball inversion accumulator
//
// a directed table walks reset values, field extremes, the zero denominator
// case and ignored register writes. Random phases with several center and
// weight settings follow. Every item is predicted in the bench and compared
// field by field with the responses, in order, under random idling and stall.
// ----------------------------------------------------------------------------
`default_nettype none

module poincare_ball_inversion_3d_top_tb;
   import pbi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC       = PBI_FRAC_BITS;
   localparam int ONE        = 1 << FRAC;
   localparam int MAXV       = 32'sh7fffffff;
   localparam int MINV       = 32'sh80000000;
   localparam int SETTLE     = FRAC + 42 + 20;
   localparam int LIMIT      = 400000;
   localparam int RAND_ITEMS = 180;

   // register indexes past the last register, writes there are dropped
   localparam logic [PBI_INDEX_BITS-1:0] SPARE_INDEX = PBI_INDEX_BITS'(4);
   localparam logic [PBI_INDEX_BITS-1:0] TOP_INDEX   = '1;

   typedef struct {
      int x;
      int y;
      int z;
      bit zd;
      bit st;
   } acc_sum_type;

   typedef struct {
      bit                        is_cfg;
      logic [PBI_INDEX_BITS-1:0] index;
      int                        data;
      int                        f[6];
      bit                        typed;
      acc_sum_type               want;
   } row_type;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      csr_valid = 0;
   logic                      csr_ready;
   logic [PBI_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0]               csr_data = '0;
   logic                      req_valid = 0;
   logic                      req_stall;
   logic signed [31:0]        req_in_x = '0, req_in_y = '0, req_in_z = '0;
   logic signed [31:0]        req_acc_x = '0, req_acc_y = '0, req_acc_z = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 0;
   logic signed [31:0]        rsp_out_x, rsp_out_y, rsp_out_z;
   logic                      rsp_zero_denominator, rsp_saturated;

   int          center_x, center_y, center_z, weight;
   acc_sum_type pending_sums[$];
   row_type     table_rows[$];
   int          errors = 0;
   int          checked = 0;
   int          zero_seen = 0;
   int          sat_seen = 0;
   int          cycles = 0;
   bit          calm = 0;
   bit          hold_req = 0;
   bit          hold_seen = 0;
   int          hold_cnt = 0;

   poincare_ball_inversion_3d_top i_dut (.*);

   always #10 clock = ~clock;

   function automatic int clip32(longint v);
      if (v > longint'(MAXV)) return MAXV;
      if (v < longint'(MINV)) return MINV;
      return int'(v);
   endfunction

   function automatic int qmul(int a, int b);
      return clip32((longint'(a) * longint'(b)) >>> FRAC);
   endfunction

   function automatic acc_sum_type inversion_sum(int x, int y, int z, int ax, int ay, int az);
      acc_sum_type r;
      int sqx, sqy, sqz, c2, c2x, c2y, c2z, s2x, s2y, s2z, r2, kx, ky, kz, den, d;
      int nx, ny, nz;
      longint ox, oy, oz;
      sqx = qmul(center_x, center_x);
      sqy = qmul(center_y, center_y);
      sqz = qmul(center_z, center_z);
      c2  = clip32(longint'(sqx) + sqy + sqz);
      c2x = clip32(2 * longint'(center_x));
      c2y = clip32(2 * longint'(center_y));
      c2z = clip32(2 * longint'(center_z));
      s2x = clip32(longint'(sqx) - sqy - sqz + ONE);
      s2y = clip32(longint'(sqy) - sqx - sqz + ONE);
      s2z = clip32(longint'(sqz) - sqy - sqx + ONE);
      r2  = clip32(longint'(qmul(x, x)) + qmul(y, y) + qmul(z, z));
      kx  = qmul(c2x, x);
      ky  = qmul(c2y, y);
      kz  = qmul(c2z, z);
      den = clip32(longint'(qmul(c2, r2)) - kx - ky - kz + ONE);
      if (den == 0) begin
         r = '{ax, ay, az, 1'b1, 1'b0};
         return r;
      end
      d  = clip32((longint'(weight) * ONE) / longint'(den));
      nx = clip32(longint'(qmul(x, s2x)) +
                  qmul(center_x, clip32(longint'(ky) + kz - r2 - ONE)));
      ny = clip32(longint'(qmul(y, s2y)) +
                  qmul(center_y, clip32(longint'(kx) + kz - r2 - ONE)));
      nz = clip32(longint'(qmul(z, s2z)) +
                  qmul(center_z, clip32(longint'(ky) + kx - r2 - ONE)));
      ox = longint'(ax) + ((longint'(d) * nx) >>> FRAC);
      oy = longint'(ay) + ((longint'(d) * ny) >>> FRAC);
      oz = longint'(az) + ((longint'(d) * nz) >>> FRAC);
      r.x  = clip32(ox);
      r.y  = clip32(oy);
      r.z  = clip32(oz);
      r.zd = 0;
      r.st = (longint'(r.x) != ox) || (longint'(r.y) != oy) || (longint'(r.z) != oz);
      return r;
   endfunction

   function automatic int rand_coord();
      int k;
      k = $urandom_range(99);
      if (k < 60) return int'($urandom_range(524287)) - 262144;
      if (k < 85) return int'($urandom);
      case ($urandom_range(4))
         0: return 0;
         1: return MAXV;
         2: return MINV;
         3: return ONE;
         default: return -ONE;
      endcase
   endfunction

   task automatic drain();
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [PBI_INDEX_BITS-1:0] idx, int val);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         PBI_REG_CENTER_X: center_x = val;
         PBI_REG_CENTER_Y: center_y = val;
         PBI_REG_CENTER_Z: center_z = val;
         PBI_REG_WEIGHT:   weight   = val;
         default: ;
      endcase
   endtask

   task automatic send_item(int f[6], bit typed, acc_sum_type want);
      req_valid <= 1;
      req_in_x  <= f[0];
      req_in_y  <= f[1];
      req_in_z  <= f[2];
      req_acc_x <= f[3];
      req_acc_y <= f[4];
      req_acc_z <= f[5];
      do @(posedge clock); while (req_stall);
      pending_sums.push_back(typed ? want : inversion_sum(f[0], f[1], f[2], f[3], f[4], f[5]));
      if (!calm && $urandom_range(99) < 18) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic add_item(int x, int y, int z, int ax, int ay, int az);
      row_type r;
      r = '{default: '0};
      r.f = '{x, y, z, ax, ay, az};
      table_rows.push_back(r);
   endtask

   task automatic add_zero_den(int ax, int ay, int az);
      row_type r;
      r = '{default: '0};
      r.f = '{ONE, 0, 0, ax, ay, az};
      r.typed = 1;
      r.want = '{ax, ay, az, 1'b1, 1'b0};
      table_rows.push_back(r);
   endtask

   task automatic add_cfg(logic [PBI_INDEX_BITS-1:0] idx, int val);
      row_type r;
      r = '{default: '0};
      r.is_cfg = 1;
      r.index = idx;
      r.data = val;
      table_rows.push_back(r);
   endtask

   task automatic set_all(int cx, int cy, int cz, int w);
      csr_write(PBI_REG_CENTER_X, cx);
      csr_write(PBI_REG_CENTER_Y, cy);
      csr_write(PBI_REG_CENTER_Z, cz);
      csr_write(PBI_REG_WEIGHT, w);
   endtask

   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_cnt  <= 400;
         rsp_stall <= 1;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 18);
      end
   end

   always @(posedge clock) begin
      acc_sum_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected item out=%h %h %h", $time, rsp_out_x, rsp_out_y,
                     rsp_out_z);
            errors++;
         end else begin
            w = pending_sums.pop_front();
            checked++;
            zero_seen += rsp_zero_denominator;
            sat_seen += rsp_saturated;
            if (rsp_out_x !== w.x || rsp_out_y !== w.y || rsp_out_z !== w.z ||
                rsp_zero_denominator !== w.zd || rsp_saturated !== w.st) begin
               $display("%0t: mismatch expected %h %h %h zd=%0b sat=%0b actual %h %h %h zd=%b sat=%b",
                        $time, w.x, w.y, w.z, w.zd, w.st, rsp_out_x, rsp_out_y, rsp_out_z,
                        rsp_zero_denominator, rsp_saturated);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int f[6];
      acc_sum_type none;
      int ph;
      none = '{default: '0};
      center_x = 0;
      center_y = 0;
      center_z = 0;
      weight = ONE;

      add_item(0, 0, 0, 0, 0, 0);
      add_item(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
      add_item(MINV, MINV, MINV, MINV, MINV, MINV);
      add_item(ONE, -ONE, ONE, 3, -3, 0);
      add_cfg(PBI_REG_CENTER_X, ONE);
      add_zero_den(5, -7, MAXV);
      add_zero_den(MINV, MINV, MINV);
      add_item(MAXV, MINV, 0, MINV, MAXV, 0);
      add_item(ONE / 2, ONE / 4, -ONE, 100, 200, 300);
      add_cfg(PBI_REG_WEIGHT, MAXV);
      add_cfg(PBI_REG_CENTER_Y, MINV);
      add_cfg(PBI_REG_CENTER_Z, MAXV);
      add_item(ONE, ONE, ONE, MAXV, MINV, MAXV);
      add_item(-ONE, 0, ONE, MINV, MAXV, MINV);
      add_cfg(SPARE_INDEX, 32'h12345678);
      add_cfg(TOP_INDEX, MINV);
      add_item(0, 0, 0, 1, 2, 3);
      add_cfg(PBI_REG_WEIGHT, MINV);
      add_item(ONE, ONE, ONE, 0, 0, 0);
      add_item(MAXV, MAXV, MAXV, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         if (table_rows[i].is_cfg) begin
            req_valid <= 0;
            csr_write(table_rows[i].index, table_rows[i].data);
         end else begin
            send_item(table_rows[i].f, table_rows[i].typed, table_rows[i].want);
         end
      end
      req_valid <= 0;

      for (ph = 0; ph < 7; ph++) begin
         drain();
         case (ph)
            0: set_all(0, 0, 0, ONE);
            1: set_all(ONE, 0, 0, ONE);
            2: set_all(MAXV, MINV, MAXV, MINV);
            3: set_all(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            4: set_all(MINV, MAXV, MINV, MAXV);
            5: set_all(int'($urandom_range(262143)) - 131072,
                       int'($urandom_range(262143)) - 131072,
                       int'($urandom_range(262143)) - 131072, 0);
            default: set_all(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
         endcase
         if ($urandom_range(1)) csr_write(PBI_INDEX_BITS'($urandom_range(255, 4)), $urandom);
         calm = (ph == 1);
         if (ph == 3) hold_req = !hold_req;
         repeat (RAND_ITEMS) begin
            foreach (f[k]) f[k] = rand_coord();
            if (center_x == ONE && center_y == 0 && center_z == 0 &&
                $urandom_range(9) == 0) begin
               f[0] = ONE;
               f[1] = 0;
               f[2] = 0;
            end
            send_item(f, 0, none);
         end
         req_valid <= 0;
         calm = 0;
      end

      drain();
      $display("covered %0d checked items over 7 settings, %0d with zero denominator,",
               checked, zero_seen);
      $display("%0d saturated, with random idling and a long receiver hold", sat_seen);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
